### src/ccix_pkg.sv
// Shared types for the circle-circle intersection pipeline.
`default_nettype none

package ccix_pkg;

   typedef struct packed {
      logic advance;
      logic valid;
   } ccix_ctl_type;

endpackage

`default_nettype wire

### src/ccix_sqrt.sv
// Pipelined rounded integer square root, one root bit per stage, several lanes.
`default_nettype none

module ccix_sqrt #(
   parameter int IW = 50,
   parameter int LANES = 1,
   parameter int PW = 1,
   localparam int QW = IW / 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccix_pkg::ccix_ctl_type        in_ctl,
   input  logic [LANES-1:0][IW-1:0]      in_rad,
   input  logic [PW-1:0]                 in_pay,
   output logic                          out_valid,
   output logic [LANES-1:0][QW:0]        out_root,
   output logic [PW-1:0]                 out_pay
);
   import ccix_pkg::*;

   localparam int RW = QW + 2;

   logic [LANES-1:0][IW-1:0] rad_t  [0:QW];
   logic [LANES-1:0][RW-1:0] rem_t  [0:QW];
   logic [LANES-1:0][QW-1:0] root_t [0:QW];
   logic [PW-1:0]            pay_t  [0:QW];
   logic [QW:0]              vld_t;

   logic                     fin_vld_ff;
   logic [LANES-1:0][QW:0]   fin_root_ff, fin_root_in;
   logic [PW-1:0]            fin_pay_ff;

   assign rad_t[0]  = in_rad;
   assign rem_t[0]  = '0;
   assign root_t[0] = '0;
   assign pay_t[0]  = in_pay;
   assign vld_t[0]  = in_ctl.valid;

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [LANES-1:0][IW-1:0] rad_ff, rad_in;
      logic [LANES-1:0][RW-1:0] rem_ff, rem_in;
      logic [LANES-1:0][QW-1:0] root_ff, root_in;
      logic [PW-1:0]            pay_ff;
      logic                     vld_ff;

      always_comb begin : step_logic
         logic [RW+1:0] cur;
         logic [RW+1:0] trial;
         for (int l = 0; l < LANES; l++) begin
            cur   = {rem_t[k-1][l], rad_t[k-1][l][IW-1 -: 2]};
            trial = {2'b00, root_t[k-1][l], 2'b01};
            if (cur >= trial) begin
               rem_in[l]  = RW'(cur - trial);
               root_in[l] = {root_t[k-1][l][QW-2:0], 1'b1};
            end else begin
               rem_in[l]  = cur[RW-1:0];
               root_in[l] = {root_t[k-1][l][QW-2:0], 1'b0};
            end
            rad_in[l] = {rad_t[k-1][l][IW-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (in_ctl.advance) begin
            vld_ff <= vld_t[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            pay_ff  <= pay_t[k-1];
         end
      end

      assign rad_t[k]  = rad_ff;
      assign rem_t[k]  = rem_ff;
      assign root_t[k] = root_ff;
      assign pay_t[k]  = pay_ff;
      assign vld_t[k]  = vld_ff;
   end

   // The remainder is rad minus root squared; round up when it exceeds the root.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         fin_root_in[l] = {1'b0, root_t[QW][l]}
                        + (QW+1)'(rem_t[QW][l] > {2'b00, root_t[QW][l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (in_ctl.advance) begin
         fin_vld_ff <= vld_t[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         fin_root_ff <= fin_root_in;
         fin_pay_ff  <= pay_t[QW];
      end
   end

   assign out_valid = fin_vld_ff;
   assign out_root  = fin_root_ff;
   assign out_pay   = fin_pay_ff;

endmodule

`default_nettype wire

### src/ccix_div.sv
// Pipelined unsigned divider rounding half up, one quotient bit per stage, shared divisor.
`default_nettype none

module ccix_div #(
   parameter int NW = 53,
   parameter int DW = 27,
   parameter int LANES = 1,
   parameter int PW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccix_pkg::ccix_ctl_type        in_ctl,
   input  logic [LANES-1:0][NW-1:0]      in_num,
   input  logic [DW-1:0]                 in_den,
   input  logic [PW-1:0]                 in_pay,
   output logic                          out_valid,
   output logic [LANES-1:0][NW-1:0]      out_quot,
   output logic [PW-1:0]                 out_pay
);
   import ccix_pkg::*;

   logic [LANES-1:0][NW-1:0] num_t [0:NW];
   logic [LANES-1:0][DW-1:0] rem_t [0:NW];
   logic [LANES-1:0][NW-1:0] quo_t [0:NW];
   logic [DW-1:0]            den_t [0:NW];
   logic [PW-1:0]            pay_t [0:NW];
   logic [NW:0]              vld_t;

   logic                     fin_vld_ff;
   logic [LANES-1:0][NW-1:0] fin_quot_ff, fin_quot_in;
   logic [PW-1:0]            fin_pay_ff;

   assign num_t[0] = in_num;
   assign rem_t[0] = '0;
   assign quo_t[0] = '0;
   assign den_t[0] = in_den;
   assign pay_t[0] = in_pay;
   assign vld_t[0] = in_ctl.valid;

   for (genvar k = 1; k <= NW; k++) begin : g_step
      logic [LANES-1:0][NW-1:0] num_ff, num_in;
      logic [LANES-1:0][DW-1:0] rem_ff, rem_in;
      logic [LANES-1:0][NW-1:0] quo_ff, quo_in;
      logic [DW-1:0]            den_ff;
      logic [PW-1:0]            pay_ff;
      logic                     vld_ff;

      always_comb begin : step_logic
         logic [DW:0] cur;
         logic        ge;
         for (int l = 0; l < LANES; l++) begin
            cur = {rem_t[k-1][l], num_t[k-1][l][NW-1]};
            ge  = (cur >= {1'b0, den_t[k-1]});
            if (ge) begin
               rem_in[l] = DW'(cur - {1'b0, den_t[k-1]});
            end else begin
               rem_in[l] = cur[DW-1:0];
            end
            quo_in[l] = {quo_t[k-1][l][NW-2:0], ge};
            num_in[l] = {num_t[k-1][l][NW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (in_ctl.advance) begin
            vld_ff <= vld_t[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            num_ff <= num_in;
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            den_ff <= den_t[k-1];
            pay_ff <= pay_t[k-1];
         end
      end

      assign num_t[k] = num_ff;
      assign rem_t[k] = rem_ff;
      assign quo_t[k] = quo_ff;
      assign den_t[k] = den_ff;
      assign pay_t[k] = pay_ff;
      assign vld_t[k] = vld_ff;
   end

   // Round up when twice the remainder reaches the divisor.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         fin_quot_in[l] = quo_t[NW][l]
                        + NW'({rem_t[NW][l], 1'b0} >= {1'b0, den_t[NW]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (in_ctl.advance) begin
         fin_vld_ff <= vld_t[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         fin_quot_ff <= fin_quot_in;
         fin_pay_ff  <= pay_t[NW];
      end
   end

   assign out_valid = fin_vld_ff;
   assign out_quot  = fin_quot_ff;
   assign out_pay   = fin_pay_ff;

endmodule

`default_nettype wire

### src/circle_circle_intersection.sv
// Top level of the circle-circle intersection pipeline with output skid buffer.
// Throughput is one word per cycle while the skid buffer is empty; the two square
// root units and two dividers are fully pipelined, one result bit per stage, and set
// the depth.
// Reset is synchronous and clears only the valid bits and the skid buffer.
`default_nettype none

module circle_circle_intersection #(
   parameter int COORD_WIDTH = 24,
   localparam int RSP_DW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // first_center_x, first_center_y, first_rim_x, first_rim_y,
   // second_center_x, second_center_y, second_rim_x, second_rim_y
   input  logic [8*COORD_WIDTH-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // first_point_x, first_point_y, second_point_x, second_point_y, zero fill
   output logic [RSP_DW-1:0]          rsp_tdata,
   // found
   output logic [0:0]                 rsp_tuser
);
   import ccix_pkg::*;

   localparam int W = COORD_WIDTH;

   typedef struct packed {
      logic signed [W:0]   vx;
      logic signed [W:0]   vy;
      logic signed [W-1:0] c1x;
      logic signed [W-1:0] c1y;
   } geo_type;

   typedef struct packed {
      logic            neg;
      logic            found;
      logic [2*W+3:0]  r1s;
      logic [W+1:0]    d;
      geo_type         geo;
   } apay_type;

   typedef struct packed {
      logic              found;
      logic signed [W+3:0] a;
      logic [W+1:0]      d;
      geo_type           geo;
   } hpay_type;

   typedef struct packed {
      logic                found;
      logic [3:0]          neg;
      logic signed [W-1:0] c1x;
      logic signed [W-1:0] c1y;
   } ppay_type;

   logic en;

   logic signed [W-1:0] fld [8];
   for (genvar i = 0; i < 8; i++) begin : g_fld
      assign fld[i] = req_tdata[i*W +: W];
   end

   // Stage 0: offsets from the centers.
   logic              v0_ff;
   logic signed [W:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   geo_type           geo0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1x_ff      <= (W+1)'(fld[2]) - (W+1)'(fld[0]);
         e1y_ff      <= (W+1)'(fld[3]) - (W+1)'(fld[1]);
         e2x_ff      <= (W+1)'(fld[6]) - (W+1)'(fld[4]);
         e2y_ff      <= (W+1)'(fld[7]) - (W+1)'(fld[5]);
         geo0_ff.vx  <= (W+1)'(fld[4]) - (W+1)'(fld[0]);
         geo0_ff.vy  <= (W+1)'(fld[5]) - (W+1)'(fld[1]);
         geo0_ff.c1x <= fld[0];
         geo0_ff.c1y <= fld[1];
      end
   end

   // Stage 1: squares.
   logic                  v1_ff;
   logic signed [2*W+1:0] sq_ff [6];
   geo_type               geo1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= e1x_ff * e1x_ff;
         sq_ff[1] <= e1y_ff * e1y_ff;
         sq_ff[2] <= e2x_ff * e2x_ff;
         sq_ff[3] <= e2y_ff * e2y_ff;
         sq_ff[4] <= geo0_ff.vx * geo0_ff.vx;
         sq_ff[5] <= geo0_ff.vy * geo0_ff.vy;
         geo1_ff  <= geo0_ff;
      end
   end

   // Stage 2: squared lengths.
   logic                     v2_ff;
   logic [2:0][2*W+1:0]      len2_ff;
   geo_type                  geo2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len2_ff[0] <= {1'b0, sq_ff[0][2*W:0]} + {1'b0, sq_ff[1][2*W:0]};
         len2_ff[1] <= {1'b0, sq_ff[2][2*W:0]} + {1'b0, sq_ff[3][2*W:0]};
         len2_ff[2] <= {1'b0, sq_ff[4][2*W:0]} + {1'b0, sq_ff[5][2*W:0]};
         geo2_ff    <= geo1_ff;
      end
   end

   logic               vr;
   logic [2:0][W+1:0]  roots;
   geo_type            geor;

   ccix_sqrt #(.IW(2*W+2), .LANES(3), .PW($bits(geo_type))) u_len_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ccix_ctl_type'{advance: en, valid: v2_ff}),
      .in_rad   (len2_ff),
      .in_pay   (geo2_ff),
      .out_valid(vr),
      .out_root (roots),
      .out_pay  (geor)
   );

   // Stage 3: crossing test and squares of the radii and distance.
   logic            v3_ff, found3_ff;
   logic [2*W+3:0]  r1s3_ff, r2s3_ff, ds3_ff;
   logic [W+1:0]    d3_ff;
   geo_type         geo3_ff;
   logic [W+1:0]    rdiff;
   logic [W+2:0]    rsum;

   assign rdiff = (roots[0] > roots[1]) ? roots[0] - roots[1] : roots[1] - roots[0];
   assign rsum  = {1'b0, roots[0]} + {1'b0, roots[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= vr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         found3_ff <= (roots[2] != '0) && ({1'b0, roots[2]} < rsum) && (roots[2] > rdiff);
         r1s3_ff   <= roots[0] * roots[0];
         r2s3_ff   <= roots[1] * roots[1];
         ds3_ff    <= roots[2] * roots[2];
         d3_ff     <= roots[2];
         geo3_ff   <= geor;
      end
   end

   // Stage 4: numerator of the meet distance.
   logic signed [2*W+5:0] num4;
   logic                  v4_ff;
   logic [2*W+4:0]        nmag4_ff;
   logic [W+2:0]          den4_ff;
   apay_type              apay4_ff;

   assign num4 = {2'b00, r1s3_ff} - {2'b00, r2s3_ff} + {2'b00, ds3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag4_ff       <= num4[2*W+5] ? (2*W+5)'(-num4) : num4[2*W+4:0];
         den4_ff        <= {d3_ff, 1'b0};
         apay4_ff.neg   <= num4[2*W+5];
         apay4_ff.found <= found3_ff;
         apay4_ff.r1s   <= r1s3_ff;
         apay4_ff.d     <= d3_ff;
         apay4_ff.geo   <= geo3_ff;
      end
   end

   logic                  va;
   logic [0:0][2*W+4:0]   aquot;
   apay_type              apay;

   ccix_div #(.NW(2*W+5), .DW(W+3), .LANES(1), .PW($bits(apay_type))) u_meet_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ccix_ctl_type'{advance: en, valid: v4_ff}),
      .in_num   (nmag4_ff),
      .in_den   (den4_ff),
      .in_pay   (apay4_ff),
      .out_valid(va),
      .out_quot (aquot),
      .out_pay  (apay)
   );

   // Stage 5: signed meet distance.
   logic                v5_ff;
   logic signed [W+3:0] a5_ff;
   apay_type            apay5_ff;
   logic [W+3:0]        amag;

   assign amag = {1'b0, aquot[0][W+2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= va;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a5_ff    <= apay.neg ? -amag : amag;
         apay5_ff <= apay;
      end
   end

   // Stage 6: square of the meet distance.
   logic                  v6_ff;
   logic signed [2*W+7:0] a2_6_ff;
   logic signed [W+3:0]   a6_ff;
   apay_type              apay6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_6_ff  <= a5_ff * a5_ff;
         a6_ff    <= a5_ff;
         apay6_ff <= apay5_ff;
      end
   end

   // Stage 7: squared half chord, clamped at zero.
   logic            v7_ff;
   logic [0:0][2*W+3:0] h2_7_ff;
   hpay_type        hpay7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (a2_6_ff[2*W+6:0] > {3'b000, apay6_ff.r1s}) begin
            h2_7_ff[0] <= '0;
         end else begin
            h2_7_ff[0] <= apay6_ff.r1s - a2_6_ff[2*W+3:0];
         end
         hpay7_ff.found <= apay6_ff.found;
         hpay7_ff.a     <= a6_ff;
         hpay7_ff.d     <= apay6_ff.d;
         hpay7_ff.geo   <= apay6_ff.geo;
      end
   end

   logic              vh;
   logic [0:0][W+2:0] hroot;
   hpay_type          hpay;

   ccix_sqrt #(.IW(2*W+4), .LANES(1), .PW($bits(hpay_type))) u_chord_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ccix_ctl_type'{advance: en, valid: v7_ff}),
      .in_rad   (h2_7_ff),
      .in_pay   (hpay7_ff),
      .out_valid(vh),
      .out_root (hroot),
      .out_pay  (hpay)
   );

   // Stage 8: products with the center line.
   logic                  v8_ff;
   logic signed [2*W+4:0] ax8_ff, ay8_ff, hx8_ff, hy8_ff;
   ppay_type              ppay8_ff;
   logic [W+1:0]          d8_ff;
   logic signed [W+3:0]   hs;

   assign hs = {1'b0, hroot[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= vh;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax8_ff       <= hpay.geo.vx * hpay.a;
         ay8_ff       <= hpay.geo.vy * hpay.a;
         hx8_ff       <= hpay.geo.vx * hs;
         hy8_ff       <= hpay.geo.vy * hs;
         d8_ff        <= hpay.d;
         ppay8_ff.found <= hpay.found;
         ppay8_ff.neg   <= '0;
         ppay8_ff.c1x   <= hpay.geo.c1x;
         ppay8_ff.c1y   <= hpay.geo.c1y;
      end
   end

   // Stage 9: point numerators split into sign and magnitude.
   logic signed [2*W+5:0] pn [4];
   logic                  v9_ff;
   logic [3:0][2*W+5:0]   pmag9_ff;
   logic [W+1:0]          d9_ff;
   ppay_type              ppay9_ff;

   assign pn[0] = (2*W+6)'(ax8_ff) + (2*W+6)'(hy8_ff);
   assign pn[1] = (2*W+6)'(ay8_ff) - (2*W+6)'(hx8_ff);
   assign pn[2] = (2*W+6)'(ax8_ff) - (2*W+6)'(hy8_ff);
   assign pn[3] = (2*W+6)'(ay8_ff) + (2*W+6)'(hx8_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 4; l++) begin
            pmag9_ff[l]     <= pn[l][2*W+5] ? -pn[l] : pn[l];
            ppay9_ff.neg[l] <= pn[l][2*W+5];
         end
         ppay9_ff.found <= ppay8_ff.found;
         ppay9_ff.c1x   <= ppay8_ff.c1x;
         ppay9_ff.c1y   <= ppay8_ff.c1y;
         d9_ff          <= d8_ff;
      end
   end

   logic                vp;
   logic [3:0][2*W+5:0] pquot;
   ppay_type            ppay;

   ccix_div #(.NW(2*W+6), .DW(W+2), .LANES(4), .PW($bits(ppay_type))) u_point_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ccix_ctl_type'{advance: en, valid: v9_ff}),
      .in_num   (pmag9_ff),
      .in_den   (d9_ff),
      .in_pay   (ppay9_ff),
      .out_valid(vp),
      .out_quot (pquot),
      .out_pay  (ppay)
   );

   // Stage 10: add the first center and saturate; points are zero without a crossing.
   logic                  po_vld_ff, po_found_ff;
   logic [3:0][W-1:0]     po_pt_ff, po_pt_in;

   always_comb begin : point_sum
      logic [W+3:0]        qmag;
      logic signed [W+3:0] off;
      logic signed [W+4:0] sum;
      for (int l = 0; l < 4; l++) begin
         qmag = {1'b0, pquot[l][W+2:0]};
         off  = ppay.neg[l] ? -qmag : qmag;
         sum  = (W+5)'(((l % 2) == 0) ? ppay.c1x : ppay.c1y) + (W+5)'(off);
         if (!ppay.found) begin
            po_pt_in[l] = '0;
         end else if ((sum[W+4:W-1] == '0) || (sum[W+4:W-1] == '1)) begin
            po_pt_in[l] = sum[W-1:0];
         end else if (sum[W+4]) begin
            po_pt_in[l] = {1'b1, {(W-1){1'b0}}};
         end else begin
            po_pt_in[l] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         po_vld_ff <= 1'b0;
      end else if (en) begin
         po_vld_ff <= vp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         po_found_ff <= ppay.found;
         po_pt_ff    <= po_pt_in;
      end
   end

   // Output register with a one-word skid buffer.
   logic              out_vld_ff, out_found_ff;
   logic [3:0][W-1:0] out_pt_ff;
   logic              skid_vld_ff, skid_found_ff;
   logic [3:0][W-1:0] skid_pt_ff;
   logic              take_out;

   assign en = ~skid_vld_ff;
   assign req_tready = en;

   assign take_out = ~out_vld_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         if (take_out) begin
            out_vld_ff <= po_vld_ff;
         end else if (po_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take_out) begin
         out_vld_ff  <= 1'b1;
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (take_out) begin
            out_found_ff <= po_found_ff;
            out_pt_ff    <= po_pt_ff;
         end else begin
            skid_found_ff <= po_found_ff;
            skid_pt_ff    <= po_pt_ff;
         end
      end else if (take_out) begin
         out_found_ff <= skid_found_ff;
         out_pt_ff    <= skid_pt_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DW'(out_pt_ff);
   assign rsp_tuser  = out_found_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid buffer holds a word while the output register is empty");

   a_no_cross_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("points are not zero on a word without a crossing");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without a stalled output");

endmodule

`default_nettype wire
